// ----- rtl/tdhh_pkg.sv -----
// Package for the TDC record hit histogrammer: widths, opcodes, record types
// and the command and status structs between controller and datapath.
// No dependencies.
package tdhh_pkg;

	localparam int CHANNELS_DEFAULT    = 256;
	localparam int COUNT_WIDTH_DEFAULT = 32;
	localparam int SUBSYSTEMS          = 4;
	localparam int SUB_W               = 2;

	localparam int OPCODE_W    = 3;
	localparam int WORD_W      = 32;
	localparam int CHAN_W      = 8;
	localparam int HALF_W      = 16;
	localparam int IDX_W       = 14;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	localparam logic [OPCODE_W-1:0] OP_DATA   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_HIT    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_OVF    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_EVT    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_MAXLEN = 3'd4;

	localparam logic [HALF_W-1:0] TYPE_EVENT   = 16'h8000;
	localparam logic [HALF_W-1:0] TYPE_SETUP   = 16'h8001;
	localparam logic [HALF_W-1:0] TYPE_TEXT    = 16'h8002;
	localparam logic [HALF_W-1:0] MARKER_SETUP = 16'h7FFF;
	localparam logic [HALF_W-1:0] MARKER_RESET = 16'hFFFF;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_clear;
	} dp_stat_t;

endpackage

// ----- rtl/tdhh_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tdhh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tdhh_ctrl.sv -----
// Controller of the histogrammer: clear sweep, input and output handshake,
// and the read and commit steps of each item. Depends on tdhh_pkg.
module tdhh_ctrl import tdhh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_READ   = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign s_tready     = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid     = out_valid_q;
	assign cmd.load     = s_tvalid && s_tready;
	assign cmd.clr_step = (state_q == S_CLEAR);
	assign cmd.commit   = (state_q == S_COMMIT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd.load) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = stat.need_clear ? S_CLEAR : S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/tdhh_dp.sv -----
// Datapath of the histogrammer: record parser state, event totals, the hit
// and overflow count RAMs and the result register. Depends on tdhh_pkg and
// tdhh_ram.
module tdhh_dp import tdhh_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEFAULT,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_stat_t               stat,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic [OPCODE_W-1:0]    in_tuser,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int CH_W   = $clog2(CHANNELS);
	localparam int ADDR_W = SUB_W + CH_W;
	localparam int DEPTH  = SUBSYSTEMS << CH_W;
	localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_EVENT  = 3'd1;
	localparam logic [2:0] PH_SETUP  = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_HALT   = 3'd4;

	logic [OPCODE_W-1:0]    op_q;
	logic [WORD_W-1:0]      word_q;
	logic [SUB_W-1:0]       rsub_q;
	logic [CHAN_W-1:0]      rch_q;

	logic [2:0]             phase_q, phase_d;
	logic [IDX_W-1:0]       widx_q, widx_d;
	logic [IDX_W-1:0]       rwords_q, rwords_d;
	logic [SUB_W-1:0]       cur_sub_q, cur_sub_d;
	logic                   trig_q, trig_d;
	logic [HALF_W-1:0]      marker_q, marker_d;
	logic [HALF_W-1:0]      maxlen_q, maxlen_d;
	logic                   events_q, events_d;
	logic                   err_q, err_d;
	logic [COUNT_WIDTH-1:0] evt_q [SUBSYSTEMS];
	logic                   evt_clr;
	logic                   evt_inc;

	logic [ADDR_W-1:0]      clr_addr_q;
	logic [WORD_W-1:0]      read_data_q;
	logic                   out_err_q;
	logic                   out_ev_q;

	logic [HALF_W-1:0]      upper;
	logic [HALF_W-1:0]      lower;
	logic [CHAN_W-1:0]      hit_ch;
	logic                   hit_ch_ok;
	logic                   rd_ch_ok;
	logic                   is_hit;
	logic                   ovf_match;
	logic [ADDR_W-1:0]      raddr;
	logic [ADDR_W-1:0]      waddr;
	logic                   we_hit;
	logic                   we_ovf;
	logic [COUNT_WIDTH-1:0] hit_rdata;
	logic [COUNT_WIDTH-1:0] ovf_rdata;
	logic [COUNT_WIDTH-1:0] hit_wdata;
	logic [COUNT_WIDTH-1:0] ovf_wdata;
	logic [WORD_W-1:0]      read_data_d;
	logic [IDX_W-1:0]       rw_len;
	logic [IDX_W-1:0]       widx_nx;

	assign upper     = word_q[WORD_W-1:HALF_W];
	assign lower     = word_q[HALF_W-1:0];
	assign hit_ch    = upper[CHAN_W-1:0];
	assign hit_ch_ok = {1'b0, hit_ch} < CH_LIMIT;
	assign rd_ch_ok  = {1'b0, rch_q} < CH_LIMIT;
	assign ovf_match = (lower == marker_q);
	assign is_hit    = (op_q == OP_DATA) && (phase_q == PH_EVENT) &&
	                   (widx_q >= IDX_W'(3)) && hit_ch_ok;
	assign raddr     = (op_q == OP_DATA) ? {cur_sub_q, hit_ch[CH_W-1:0]}
	                                     : {rsub_q, rch_q[CH_W-1:0]};
	assign waddr     = cmd.clr_step ? clr_addr_q : raddr;
	assign we_hit    = cmd.clr_step || (cmd.commit && is_hit && !ovf_match);
	assign we_ovf    = cmd.clr_step || (cmd.commit && is_hit && ovf_match);
	assign hit_wdata = cmd.clr_step ? '0 : hit_rdata + COUNT_WIDTH'(1);
	assign ovf_wdata = cmd.clr_step ? '0 : ovf_rdata + COUNT_WIDTH'(1);

	assign stat.clr_last   = &clr_addr_q;
	assign stat.need_clear = (op_q == OP_DATA) && (phase_q == PH_HEADER) &&
	                         (upper == TYPE_SETUP);

	tdhh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_hit_ram (
		.clk   (clk),
		.we    (we_hit),
		.waddr (waddr),
		.wdata (hit_wdata),
		.raddr (raddr),
		.rdata (hit_rdata)
	);

	tdhh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ovf_ram (
		.clk   (clk),
		.we    (we_ovf),
		.waddr (waddr),
		.wdata (ovf_wdata),
		.raddr (raddr),
		.rdata (ovf_rdata)
	);

	assign rw_len  = (lower[HALF_W-1:2] == '0) ? IDX_W'(1) : lower[HALF_W-1:2];
	assign widx_nx = widx_q + IDX_W'(1);

	always_comb begin
		phase_d   = phase_q;
		widx_d    = widx_q;
		rwords_d  = rwords_q;
		cur_sub_d = cur_sub_q;
		trig_d    = trig_q;
		marker_d  = marker_q;
		maxlen_d  = maxlen_q;
		events_d  = events_q;
		err_d     = err_q;
		evt_clr   = 1'b0;
		evt_inc   = 1'b0;
		if (op_q == OP_DATA) begin
			if (phase_q == PH_HEADER) begin
				if (upper == '0) begin
					err_d = 1'b1;
				end else begin
					if (lower > maxlen_q) begin
						maxlen_d = lower;
					end
					rwords_d = rw_len;
					widx_d   = IDX_W'(1);
					priority if (upper == TYPE_EVENT) begin
						events_d = 1'b1;
						phase_d  = PH_EVENT;
					end else if (upper == TYPE_SETUP) begin
						events_d = 1'b0;
						trig_d   = 1'b0;
						evt_clr  = 1'b1;
						phase_d  = PH_SETUP;
					end else if (upper == TYPE_TEXT) begin
						phase_d = PH_SKIP;
					end else begin
						err_d   = 1'b1;
						phase_d = PH_HALT;
					end
					if ((upper == TYPE_EVENT || upper == TYPE_SETUP ||
					     upper == TYPE_TEXT) && rw_len == IDX_W'(1)) begin
						phase_d = PH_HEADER;
					end
				end
			end else if (phase_q != PH_HALT) begin
				if (phase_q == PH_EVENT && widx_q == IDX_W'(1)) begin
					cur_sub_d = upper[SUB_W-1:0] + SUB_W'(1);
					evt_inc   = 1'b1;
				end
				if (phase_q == PH_SETUP) begin
					if (widx_q == IDX_W'(4)) begin
						trig_d = (upper == '0);
					end else if (widx_q == IDX_W'(6) && trig_q && word_q[WORD_W-1]) begin
						marker_d = MARKER_SETUP;
					end
				end
				widx_d = widx_nx;
				if (widx_nx >= rwords_q) begin
					phase_d = PH_HEADER;
				end
			end
		end
	end

	always_comb begin
		unique case (op_q)
			OP_HIT:    read_data_d = rd_ch_ok ? WORD_W'(hit_rdata) : '0;
			OP_OVF:    read_data_d = rd_ch_ok ? WORD_W'(ovf_rdata) : '0;
			OP_EVT:    read_data_d = WORD_W'(evt_q[rsub_q]);
			OP_MAXLEN: read_data_d = WORD_W'(maxlen_q);
			default:   read_data_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_tuser;
			word_q <= in_tdata[WORD_W-1:0];
			rsub_q <= in_tdata[WORD_W+SUB_W-1:WORD_W];
			rch_q  <= in_tdata[WORD_W+SUB_W+CHAN_W-1:WORD_W+SUB_W];
		end
		if (cmd.commit) begin
			read_data_q <= read_data_d;
			out_err_q   <= err_d;
			out_ev_q    <= events_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			widx_q     <= '0;
			rwords_q   <= '0;
			cur_sub_q  <= '0;
			trig_q     <= 1'b0;
			marker_q   <= MARKER_RESET;
			maxlen_q   <= '0;
			events_q   <= 1'b0;
			err_q      <= 1'b0;
			clr_addr_q <= '0;
			for (int i = 0; i < SUBSYSTEMS; i++) begin
				evt_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.commit) begin
				phase_q   <= phase_d;
				widx_q    <= widx_d;
				rwords_q  <= rwords_d;
				cur_sub_q <= cur_sub_d;
				trig_q    <= trig_d;
				marker_q  <= marker_d;
				maxlen_q  <= maxlen_d;
				events_q  <= events_d;
				err_q     <= err_d;
				if (evt_clr) begin
					for (int i = 0; i < SUBSYSTEMS; i++) begin
						evt_q[i] <= '0;
					end
				end else if (evt_inc) begin
					evt_q[cur_sub_d] <= evt_q[cur_sub_d] + COUNT_WIDTH'(1);
				end
			end
		end
	end

	assign out_tdata = {{(OUT_TDATA_W - WORD_W - 2){1'b0}}, out_ev_q, out_err_q, read_data_q};

endmodule

// ----- rtl/tdc_record_hit_histogrammer.sv -----
// Top level of the TDC record hit histogrammer: controller plus datapath.
// Depends on tdhh_pkg, tdhh_ctrl, tdhh_dp and tdhh_ram.
//
// Channel  Direction  Contents
// s_*      in         tuser: opcode; tdata: data_word, read_subsystem, read_channel
// m_*      out        tdata: read_data, format_error, have_events
//
// Each item passes through the transfer, the count RAM read, and a step that
// updates the state and loads the output register. The next item is taken in
// the cycle after that step if the result leaves by then.
// After reset and after every setup record the count RAMs are cleared one
// entry per cycle, all 4 * 2**clog2(CHANNELS) entries (1024 by default), with
// s_tready low. A stalled output holds its result and blocks new items.
module tdc_record_hit_histogrammer import tdhh_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEFAULT,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// data_word[31:0], read_subsystem[33:32], read_channel[41:34], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode[2:0]
	input  logic [OPCODE_W-1:0]    s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_data[31:0], format_error[32], have_events[33], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	tdhh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdhh_dp #(.CHANNELS(CHANNELS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.out_tdata (m_tdata)
	);

endmodule

// ----- rtl/tdhh_checker.sv -----
// Port-level checker for the histogrammer, bound to the top level.
// Depends on tdhh_pkg and tdc_record_hit_histogrammer.
module tdhh_checker import tdhh_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic [OPCODE_W-1:0]    s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [1:0]          pend_q;
	logic [OPCODE_W-1:0] op_q;
	logic                err_seen_q;
	logic                in_xfer;
	logic                out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			op_q       <= OP_DATA;
			err_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
			if (in_xfer) begin
				op_q <= s_tuser;
			end
			if (out_xfer && m_tdata[WORD_W]) begin
				err_seen_q <= 1'b1;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 || pend_q == 2'd1)
		else $error("more than one item in flight");

	a_valid_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q == 2'd1)
		else $error("result without an accepted item");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_seen_q |-> m_tdata[WORD_W])
		else $error("format error flag dropped");

	a_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (op_q == OP_DATA || op_q > OP_MAXLEN) |-> m_tdata[WORD_W-1:0] == '0)
		else $error("nonzero read data for a data word or unused opcode");

endmodule

bind tdc_record_hit_histogrammer tdhh_checker u_checker (.*);

// ----- tb/tb_tdc_record_hit_histogrammer.sv -----
// Self-checking testbench for tdc_record_hit_histogrammer: drives readout words and
// count reads, tracks the record parser and histograms alongside, compares every reply.
// Depends on tdhh_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_tdc_record_hit_histogrammer;
	import tdhh_pkg::*;

	localparam int CHANNELS    = CHANNELS_DEFAULT;
	localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
	localparam int ITEM_TARGET = 1850;
	localparam int STALL_LIMIT = 8000;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;

	localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

	typedef enum logic [2:0] {EXP_HEADER, IN_EVENT, IN_SETUP, IN_TEXT, HALTED} rec_phase_e;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [WORD_W-1:0]   word;
		logic [SUB_W-1:0]    sub;
		logic [CHAN_W-1:0]   chan;
		bit                  drain;
	} stream_item_t;

	typedef struct {
		logic [WORD_W-1:0] read_data;
		logic              format_error;
		logic              have_events;
	} reply_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [OPCODE_W-1:0]    s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	tdc_record_hit_histogrammer #(
		.CHANNELS   (CHANNELS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	rec_phase_e              rec_phase;
	logic [IDX_W-1:0]        rec_pos;
	logic [IDX_W-1:0]        rec_words;
	logic [SUB_W-1:0]        cur_sub;
	bit                      trig_zero;
	logic [HALF_W-1:0]       ovf_marker;
	logic [COUNT_WIDTH-1:0]  hit_tab [SUBSYSTEMS*CHANNELS];
	logic [COUNT_WIDTH-1:0]  ovf_tab [SUBSYSTEMS*CHANNELS];
	logic [COUNT_WIDTH-1:0]  evt_tab [SUBSYSTEMS];
	logic [HALF_W-1:0]       longest_len;
	bit                      saw_events;
	bit                      sticky_err;

	stream_item_t stream_queue[$];
	reply_t       due_replies[$];
	stream_item_t offered_item;
	logic [7:0]   chan_pool [8];
	bit           drain_next;
	int unsigned  total_items;
	int unsigned  items_sent;
	int unsigned  results_seen;
	int unsigned  hold_left;
	bit           long_hold_done;
	int unsigned  stall_cycles;
	int unsigned  mismatches;

	function automatic reply_t histogram_update(input stream_item_t it);
		reply_t            r;
		logic [HALF_W-1:0] upper;
		logic [HALF_W-1:0] lower;
		int                k;
		r = '{default: '0};
		upper = it.word[31:16];
		lower = it.word[15:0];
		case (it.opcode)
			OP_DATA: begin
				if (rec_phase == EXP_HEADER) begin
					if (upper == '0) begin
						sticky_err = 1'b1;
					end else begin
						if (lower > longest_len)
							longest_len = lower;
						rec_words = lower[15:2];
						if (rec_words == '0)
							rec_words = IDX_W'(1);
						rec_pos = IDX_W'(1);
						case (upper)
							TYPE_EVENT: begin
								saw_events = 1'b1;
								rec_phase = IN_EVENT;
							end
							TYPE_SETUP: begin
								foreach (hit_tab[i]) hit_tab[i] = '0;
								foreach (ovf_tab[i]) ovf_tab[i] = '0;
								foreach (evt_tab[i]) evt_tab[i] = '0;
								saw_events = 1'b0;
								trig_zero = 1'b0;
								rec_phase = IN_SETUP;
							end
							TYPE_TEXT: rec_phase = IN_TEXT;
							default: begin
								sticky_err = 1'b1;
								rec_phase = HALTED;
							end
						endcase
						if (rec_phase != HALTED && rec_words <= 1)
							rec_phase = EXP_HEADER;
					end
				end else if (rec_phase != HALTED) begin
					if (rec_phase == IN_EVENT) begin
						if (rec_pos == 1) begin
							cur_sub = upper[1:0] + 2'd1;
							evt_tab[cur_sub] = evt_tab[cur_sub] + COUNT_WIDTH'(1);
						end else if (rec_pos >= 3 && int'(upper[7:0]) < CHANNELS) begin
							k = int'(cur_sub) * CHANNELS + int'(upper[7:0]);
							if (lower == ovf_marker)
								ovf_tab[k] = ovf_tab[k] + COUNT_WIDTH'(1);
							else
								hit_tab[k] = hit_tab[k] + COUNT_WIDTH'(1);
						end
					end else if (rec_phase == IN_SETUP) begin
						if (rec_pos == 4)
							trig_zero = (upper == '0);
						else if (rec_pos == 6 && trig_zero && it.word[31])
							ovf_marker = MARKER_SETUP;
					end
					rec_pos = rec_pos + IDX_W'(1);
					if (rec_pos >= rec_words)
						rec_phase = EXP_HEADER;
				end
			end
			OP_HIT, OP_OVF: begin
				if (int'(it.chan) < CHANNELS) begin
					k = int'(it.sub) * CHANNELS + int'(it.chan);
					r.read_data = WORD_W'((it.opcode == OP_HIT) ? hit_tab[k] : ovf_tab[k]);
				end
			end
			OP_EVT: r.read_data = WORD_W'(evt_tab[it.sub]);
			OP_MAXLEN: r.read_data = WORD_W'(longest_len);
			default: ;
		endcase
		r.format_error = sticky_err;
		r.have_events = saw_events;
		return r;
	endfunction

	task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word,
			input logic [SUB_W-1:0] sub, input logic [CHAN_W-1:0] chan);
		stream_item_t it;
		it.opcode = op;
		it.word = word;
		it.sub = sub;
		it.chan = chan;
		it.drain = drain_next;
		drain_next = 1'b0;
		stream_queue.push_back(it);
	endtask

	function automatic logic [CHAN_W-1:0] pick_channel();
		if ($urandom_range(0, 3) != 0)
			return chan_pool[$urandom_range(0, 7)];
		return CHAN_W'($urandom);
	endfunction

	task automatic push_read();
		logic [OPCODE_W-1:0] op;
		if ($urandom_range(0, 9) == 0)
			op = OP_UNUSED_LO + OPCODE_W'($urandom_range(0, 2));
		else
			op = OP_HIT + OPCODE_W'($urandom_range(0, 3));
		push_item(op, $urandom, SUB_W'($urandom), pick_channel());
	endtask

	task automatic push_record(input logic [HALF_W-1:0] rtype, input int words);
		logic [WORD_W-1:0] w;
		logic [HALF_W-1:0] low;
		push_item(OP_DATA, {rtype, HALF_W'(words * 4 + $urandom_range(0, 3))},
			SUB_W'($urandom), CHAN_W'($urandom));
		for (int i = 1; i < words; i++) begin
			w = $urandom;
			if (rtype == TYPE_EVENT && i >= 3) begin
				case ($urandom_range(0, 3))
					0: low = MARKER_RESET;
					1: low = MARKER_SETUP;
					default: low = HALF_W'($urandom);
				endcase
				w = {w[31:24], pick_channel(), low};
			end else if (rtype == TYPE_SETUP && i == 4 && $urandom_range(0, 1) == 1) begin
				w[31:16] = '0;
			end
			push_item(OP_DATA, w, SUB_W'($urandom), CHAN_W'($urandom));
			if ($urandom_range(0, 99) < 12)
				push_read();
		end
	endtask

	function automatic int unsigned sender_idle_pct(input int unsigned sent);
		if (sent < total_items / 3)
			return 36;
		if (sent < 2 * total_items / 3)
			return 59;
		return 0;
	endfunction

	function automatic int unsigned receiver_idle_pct(input int unsigned seen);
		if (seen < total_items / 3)
			return 59;
		if (seen < 2 * total_items / 3)
			return 36;
		return 0;
	endfunction

	task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
		mismatches++;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : drive_proc
		int unsigned sent_now;
		bit          offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			items_sent <= 0;
		end else begin
			sent_now = items_sent;
			if (s_tvalid && s_tready) begin
				due_replies.push_back(histogram_update(offered_item));
				sent_now++;
			end
			items_sent <= sent_now;
			if (!s_tvalid || s_tready) begin
				offer = stream_queue.size() != 0
					&& $urandom_range(0, 99) >= sender_idle_pct(sent_now);
				if (offer && stream_queue[0].drain && sent_now != results_seen)
					offer = 1'b0;
				if (offer) begin
					offered_item = stream_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_TDATA_W - 42){1'b0}}, offered_item.chan,
						offered_item.sub, offered_item.word};
					s_tuser <= offered_item.opcode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_seen <= 0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (due_replies.size() == 0) begin
					$display("%0t: unexpected output transfer, expected none, actual 0x%010h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = due_replies.pop_front();
					if (m_tdata[31:0] !== want.read_data)
						report_mismatch("read_data", want.read_data, m_tdata[31:0]);
					if (m_tdata[32] !== want.format_error)
						report_mismatch("format_error", WORD_W'(want.format_error),
							WORD_W'(m_tdata[32]));
					if (m_tdata[33] !== want.have_events)
						report_mismatch("have_events", WORD_W'(want.have_events),
							WORD_W'(m_tdata[33]));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen == HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				long_hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(0, 99) >= receiver_idle_pct(results_seen);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("FAIL tdc_record_hit_histogrammer");
			$finish;
		end
	end

	initial begin
		int unsigned directed_count;
		int unsigned pick;
		bit          mid_drain_done;
		bit          zero_header_done;
		rec_phase = EXP_HEADER;
		rec_pos = '0;
		rec_words = '0;
		cur_sub = '0;
		trig_zero = 1'b0;
		ovf_marker = MARKER_RESET;
		foreach (hit_tab[i]) hit_tab[i] = '0;
		foreach (ovf_tab[i]) ovf_tab[i] = '0;
		foreach (evt_tab[i]) evt_tab[i] = '0;
		longest_len = '0;
		saw_events = 1'b0;
		sticky_err = 1'b0;
		mismatches = 0;
		drain_next = 1'b0;
		mid_drain_done = 1'b0;
		zero_header_done = 1'b0;
		chan_pool[0] = 8'd0;
		chan_pool[1] = 8'd255;
		for (int i = 2; i < 8; i++)
			chan_pool[i] = CHAN_W'($urandom);

		push_item(OP_HIT, '1, 2'd3, 8'd255);
		push_item(OP_EVT, '0, 2'd3, 8'd0);
		push_item(OP_UNUSED_HI, '1, '1, '1);
		push_item(OP_DATA, {TYPE_EVENT, 16'h0000}, '0, '0);
		push_item(OP_DATA, {TYPE_EVENT, 16'h0018}, '0, '0);
		push_item(OP_DATA, 32'hFFFF_0000, '0, '0);
		push_item(OP_DATA, 32'h1234_5678, '0, '0);
		push_item(OP_DATA, {8'hFF, 8'hFF, MARKER_RESET}, '0, '0);
		push_item(OP_DATA, 32'h0000_0000, '0, '0);
		push_item(OP_DATA, {8'h00, 8'hFF, MARKER_SETUP}, '0, '0);
		push_item(OP_OVF, '0, 2'd0, 8'd255);
		push_item(OP_HIT, '0, 2'd0, 8'd255);
		push_item(OP_DATA, {TYPE_TEXT, 16'h0008}, '0, '0);
		push_item(OP_DATA, 32'hFFFF_FFFF, '0, '0);
		push_item(OP_DATA, {TYPE_SETUP, 16'h001C}, '0, '0);
		for (int i = 1; i < 7; i++) begin
			if (i == 4)
				push_item(OP_DATA, {16'h0000, HALF_W'($urandom)}, '0, '0);
			else if (i == 6)
				push_item(OP_DATA, {1'b1, 31'($urandom)}, '0, '0);
			else
				push_item(OP_DATA, $urandom, '0, '0);
		end
		push_item(OP_DATA, {TYPE_EVENT, 16'h0010}, '0, '0);
		push_item(OP_DATA, 32'h0002_0000, '0, '0);
		push_item(OP_DATA, $urandom, '0, '0);
		push_item(OP_DATA, {8'h00, 8'hFF, MARKER_SETUP}, '0, '0);
		push_item(OP_OVF, '0, 2'd3, 8'd255);
		push_item(OP_EVT, '0, 2'd3, 8'd0);
		directed_count = stream_queue.size();

		while (stream_queue.size() < directed_count + ITEM_TARGET) begin
			if (!mid_drain_done && stream_queue.size() >= directed_count + ITEM_TARGET / 2) begin
				drain_next = 1'b1;
				mid_drain_done = 1'b1;
			end
			if (!zero_header_done
					&& stream_queue.size() >= directed_count + 2 * ITEM_TARGET / 3) begin
				push_item(OP_DATA, {16'h0000, HALF_W'($urandom)}, '0, '0);
				zero_header_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60)
				push_record(TYPE_EVENT, ($urandom_range(0, 9) == 0) ?
					$urandom_range(13, 40) : $urandom_range(0, 12));
			else if (pick < 64)
				push_record(TYPE_SETUP, $urandom_range(0, 9));
			else if (pick < 72)
				push_record(TYPE_TEXT, $urandom_range(0, 10));
			else if (pick < 92)
				repeat ($urandom_range(1, 4)) push_read();
			else
				push_item(OP_UNUSED_LO + OPCODE_W'($urandom_range(0, 2)), $urandom,
					SUB_W'($urandom), CHAN_W'($urandom));
		end

		// An unknown record type stops all data handling for good, so it comes last.
		drain_next = 1'b1;
		push_item(OP_DATA, 32'hFFFF_FFFF, '0, '0);
		repeat (20) begin
			if ($urandom_range(0, 1) == 1)
				push_item(OP_DATA, $urandom, SUB_W'($urandom), CHAN_W'($urandom));
			else
				push_read();
		end
		push_item(OP_MAXLEN, '0, '0, '0);
		total_items = stream_queue.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_queue.size() != 0 || s_tvalid)
			@(negedge clk);
		while (results_seen != items_sent)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (due_replies.size() != 0) begin
			$display("%0t: %0d expected outputs never arrived", $time, due_replies.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS tdc_record_hit_histogrammer");
		else
			$display("FAIL tdc_record_hit_histogrammer");
		$finish;
	end

endmodule
